/* src/rcit_pkg.sv */
package rcit_pkg;

   localparam int RADIUS_WIDTH = 16;
   localparam int R2_WIDTH     = 2 * RADIUS_WIDTH;
   localparam int LANES        = 4;

   typedef logic [RADIUS_WIDTH-1:0] radius_type;
   typedef logic [R2_WIDTH-1:0]     r2_type;

endpackage

/* src/rect_circle_intersect_test_top.sv */
// Rectangle / circle intersection test.
// Request channel (req_): the four corners of a rectangle, in order around
// its outline, and a circle centre, all signed fixed point. One transfer per
// cycle is taken while the pipeline moves.
// Response channel (rsp_): one bit, rsp_hit, for each request, in order.
// CSR channel (csr_): writes the circle radius; csr_ready is always high.
// Write it only while no request is in flight.
// The five register stages (differences, products, sums, partial products,
// result) all advance together, so one test per cycle is taken while the
// receiver does not stall.
// When the receiver stalls, the whole pipeline holds and req_ready drops;
// nothing is lost or repeated.
// Reset empties the pipeline and sets the radius to one half.
module rect_circle_intersect_test_top #(
   parameter int COORD_WIDTH = 21,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_corner0_x,
   input  logic signed [COORD_WIDTH-1:0]       req_corner0_y,
   input  logic signed [COORD_WIDTH-1:0]       req_corner1_x,
   input  logic signed [COORD_WIDTH-1:0]       req_corner1_y,
   input  logic signed [COORD_WIDTH-1:0]       req_corner2_x,
   input  logic signed [COORD_WIDTH-1:0]       req_corner2_y,
   input  logic signed [COORD_WIDTH-1:0]       req_corner3_x,
   input  logic signed [COORD_WIDTH-1:0]       req_corner3_y,
   input  logic signed [COORD_WIDTH-1:0]       req_centre_x,
   input  logic signed [COORD_WIDTH-1:0]       req_centre_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rcit_pkg::RADIUS_WIDTH-1:0]   csr_radius
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;
   localparam int CM = SW - 1;
   localparam int H  = (CM + 1) / 2;
   localparam int HW = CM - H;
   localparam int RW = rcit_pkg::R2_WIDTH;
   localparam int MW = (SW > RW + 1) ? SW : RW + 1;
   localparam int XW = 2 * CM;
   localparam int N  = rcit_pkg::LANES;
   localparam logic [rcit_pkg::RADIUS_WIDTH-1:0] RADIUS_RESET =
      rcit_pkg::RADIUS_WIDTH'((64'd1 << FRAC_BITS) >> 1);

   logic en;
   logic [3:0] v_ff;
   logic rsp_valid_ff;
   rcit_pkg::radius_type radius_ff;

   logic signed [COORD_WIDTH-1:0] cx [N];
   logic signed [COORD_WIDTH-1:0] cy [N];

   logic signed [DW-1:0] ex_ff [N];
   logic signed [DW-1:0] ey_ff [N];
   logic signed [DW-1:0] dx_ff [N];
   logic signed [DW-1:0] dy_ff [N];
   logic signed [DW-1:0] ex_in [N];
   logic signed [DW-1:0] ey_in [N];
   logic signed [DW-1:0] dx_in [N];
   logic signed [DW-1:0] dy_in [N];

   logic signed [PW-1:0] exx_ff [N];
   logic signed [PW-1:0] eyy_ff [N];
   logic signed [PW-1:0] dxx_ff [N];
   logic signed [PW-1:0] dyy_ff [N];
   logic signed [PW-1:0] pxd_ff [N];
   logic signed [PW-1:0] pyd_ff [N];
   logic signed [PW-1:0] cxy_ff [N];
   logic signed [PW-1:0] cyx_ff [N];
   rcit_pkg::r2_type r2b_ff;

   logic signed [SW-1:0] dist_ff [N];
   logic signed [SW-1:0] len_ff [N];
   logic signed [SW-1:0] proj_ff [N];
   logic [CM-1:0] crm_ff [N];
   logic signed [SW-1:0] dist_in [N];
   logic signed [SW-1:0] len_in [N];
   logic signed [SW-1:0] proj_in [N];
   logic signed [SW-1:0] cr_in [N];
   logic [CM-1:0] crm_in [N];
   logic inside_c_ff;
   logic inside_c_in;
   rcit_pkg::r2_type r2c_ff;

   logic [N-1:0] near_ff;
   logic [N-1:0] zero_ff;
   logic [N-1:0] lo_ff;
   logic [N-1:0] hi_ff;
   logic [N-1:0] near_in;
   logic [N-1:0] zero_in;
   logic [N-1:0] lo_in;
   logic [N-1:0] hi_in;
   logic [2*HW-1:0] hh_ff [N];
   logic [HW+H-1:0] hl_ff [N];
   logic [2*H-1:0]  ll_ff [N];
   logic [RW+HW-1:0] rh_ff [N];
   logic [RW+H-1:0]  rl_ff [N];
   logic inside_d_ff;

   logic [XW-1:0] c2 [N];
   logic [XW-1:0] lim [N];
   logic [N-1:0] edge_hit;
   logic hit_in;
   logic rsp_hit_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[2:0], req_valid};
         rsp_valid_ff <= v_ff[3];
      end
   end

   // differences
   always_comb begin
      cx[0] = req_corner0_x;
      cy[0] = req_corner0_y;
      cx[1] = req_corner1_x;
      cy[1] = req_corner1_y;
      cx[2] = req_corner2_x;
      cy[2] = req_corner2_y;
      cx[3] = req_corner3_x;
      cy[3] = req_corner3_y;
      for (int i = 0; i < N; i++) begin
         ex_in[i] = DW'(req_centre_x) - DW'(cx[i]);
         ey_in[i] = DW'(req_centre_y) - DW'(cy[i]);
         dx_in[i] = DW'(cx[(i + 1) & 3]) - DW'(cx[i]);
         dy_in[i] = DW'(cy[(i + 1) & 3]) - DW'(cy[i]);
      end
   end

   // sums and cross magnitudes
   always_comb begin
      for (int i = 0; i < N; i++) begin
         dist_in[i] = SW'(exx_ff[i]) + SW'(eyy_ff[i]);
         len_in[i]  = SW'(dxx_ff[i]) + SW'(dyy_ff[i]);
         proj_in[i] = SW'(pxd_ff[i]) + SW'(pyd_ff[i]);
         cr_in[i]   = SW'(cxy_ff[i]) - SW'(cyx_ff[i]);
         crm_in[i]  = cr_in[i][SW-1] ? CM'(-cr_in[i]) : CM'(cr_in[i]);
      end
      inside_c_in = !cr_in[0][SW-1] && !proj_in[0][SW-1] &&
                    !cr_in[2][SW-1] && !proj_in[2][SW-1];
   end

   // flags
   always_comb begin
      for (int i = 0; i < N; i++) begin
         near_in[i] = MW'(dist_ff[i]) < MW'($signed({1'b0, r2c_ff}));
         zero_in[i] = (len_ff[i] == '0);
         lo_in[i]   = (proj_ff[i] <= $signed(SW'(0)));
         hi_in[i]   = (proj_ff[i] >= len_ff[i]);
      end
   end

   // final combine
   always_comb begin
      for (int i = 0; i < N; i++) begin
         c2[i]  = (XW'(hh_ff[i]) << (2 * H)) + (XW'(hl_ff[i]) << (H + 1)) + XW'(ll_ff[i]);
         lim[i] = (XW'(rh_ff[i]) << H) + XW'(rl_ff[i]);
         if (zero_ff[i]) begin
            edge_hit[i] = 1'b0;
         end else if (lo_ff[i]) begin
            edge_hit[i] = near_ff[i];
         end else if (hi_ff[i]) begin
            edge_hit[i] = near_ff[(i + 1) & 3];
         end else begin
            edge_hit[i] = c2[i] < lim[i];
         end
      end
      hit_in = inside_d_ff || (|near_ff) || (|edge_hit);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            ex_ff[i]  <= ex_in[i];
            ey_ff[i]  <= ey_in[i];
            dx_ff[i]  <= dx_in[i];
            dy_ff[i]  <= dy_in[i];

            exx_ff[i] <= ex_ff[i] * ex_ff[i];
            eyy_ff[i] <= ey_ff[i] * ey_ff[i];
            dxx_ff[i] <= dx_ff[i] * dx_ff[i];
            dyy_ff[i] <= dy_ff[i] * dy_ff[i];
            pxd_ff[i] <= ex_ff[i] * dx_ff[i];
            pyd_ff[i] <= ey_ff[i] * dy_ff[i];
            cxy_ff[i] <= dx_ff[i] * ey_ff[i];
            cyx_ff[i] <= dy_ff[i] * ex_ff[i];

            dist_ff[i] <= dist_in[i];
            len_ff[i]  <= len_in[i];
            proj_ff[i] <= proj_in[i];
            crm_ff[i]  <= crm_in[i];

            hh_ff[i] <= crm_ff[i][CM-1:H] * crm_ff[i][CM-1:H];
            hl_ff[i] <= crm_ff[i][CM-1:H] * crm_ff[i][H-1:0];
            ll_ff[i] <= crm_ff[i][H-1:0] * crm_ff[i][H-1:0];
            rh_ff[i] <= r2c_ff * len_ff[i][CM-1:H];
            rl_ff[i] <= r2c_ff * len_ff[i][H-1:0];
         end
         r2b_ff      <= radius_ff * radius_ff;
         inside_c_ff <= inside_c_in;
         r2c_ff      <= r2b_ff;
         near_ff     <= near_in;
         zero_ff     <= zero_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         inside_d_ff <= inside_c_ff;
         rsp_hit_ff  <= hit_in;
      end
   end

endmodule

/* src/rcit_checker.sv */
module rcit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled response changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && req_ready, 4) && !$past(reset, 4) &&
      $past(!rsp_valid, 1) && $past(!rsp_valid, 2) && $past(!rsp_valid, 3) &&
      $past(!rsp_valid, 4) && !$past(req_valid && req_ready, 1) &&
      !$past(req_valid && req_ready, 2) && !$past(req_valid && req_ready, 3) &&
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)
      |=> !rsp_valid)
      else $error("response without request");

endmodule

bind rect_circle_intersect_test_top rcit_checker u_rcit_checker (.*);

/* verif/rect_circle_checker.sv */
module rect_circle_checker #(
   parameter int COORD_WIDTH = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_corner0_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner0_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner1_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner1_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner2_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner2_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner3_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner3_y,
   input  logic signed [COORD_WIDTH-1:0] req_centre_x,
   input  logic signed [COORD_WIDTH-1:0] req_centre_y,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_hit,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  rcit_pkg::radius_type         csr_radius,
   output int                           error_count,
   output int                           pending_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_t;

   rcit_pkg::radius_type radius_reg;
   bit         hit_queue[$];

   function automatic bit near_corner(wide_t dx, wide_t dy, wide_t r2);
      return (dx * dx + dy * dy) < r2;
   endfunction

   function automatic bit near_segment(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                       wide_t px, wide_t py, wide_t r2);
      wide_t dx, dy, wx, wy, len2, proj, cr;
      dx = bx - ax;
      dy = by - ay;
      wx = px - ax;
      wy = py - ay;
      len2 = dx * dx + dy * dy;
      if (len2 == 0) return 1'b0;
      proj = wx * dx + wy * dy;
      if (proj <= 0) return near_corner(wx, wy, r2);
      if (proj >= len2) return near_corner(px - bx, py - by, r2);
      cr = dx * wy - dy * wx;
      return cr * cr < r2 * len2;
   endfunction

   function automatic bit inside_half(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                      wide_t px, wide_t py);
      wide_t ux, uy, vx, vy;
      ux = bx - ax;
      uy = by - ay;
      vx = px - ax;
      vy = py - ay;
      return (ux * vy - uy * vx) >= 0 && (ux * vx + uy * vy) >= 0;
   endfunction

   function automatic bit predict_hit(wide_t cx[4], wide_t cy[4], wide_t px, wide_t py,
                                      rcit_pkg::radius_type rad);
      wide_t r2;
      int    j;
      r2 = wide_t'(rad) * wide_t'(rad);
      if (inside_half(cx[0], cy[0], cx[1], cy[1], px, py) &&
          inside_half(cx[2], cy[2], cx[3], cy[3], px, py)) return 1'b1;
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         if (near_corner(px - cx[i], py - cy[i], r2) ||
             near_segment(cx[i], cy[i], cx[j], cy[j], px, py, r2)) return 1'b1;
      end
      return 1'b0;
   endfunction

   assign pending_hits = hit_queue.size();

   always @(posedge clock) begin
      wide_t cx[4], cy[4];
      bit    want;
      if (reset) begin
         radius_reg <= rcit_pkg::radius_type'(128);
         hit_queue.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) radius_reg <= csr_radius;
         if (req_valid && req_ready) begin
            cx[0] = req_corner0_x; cy[0] = req_corner0_y;
            cx[1] = req_corner1_x; cy[1] = req_corner1_y;
            cx[2] = req_corner2_x; cy[2] = req_corner2_y;
            cx[3] = req_corner3_x; cy[3] = req_corner3_y;
            hit_queue.push_back(predict_hit(cx, cy, req_centre_x, req_centre_y,
                                            radius_reg));
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $error("unexpected response transfer, hit=%0b", rsp_hit);
               error_count <= error_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (want !== rsp_hit) begin
                  $error("hit mismatch: expected %0b actual %0b", want, rsp_hit);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

/* verif/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 21;
   localparam int CMIN = -(1 << (CW - 1));
   localparam int CMAX = (1 << (CW - 1)) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic signed [CW-1:0] crd[10] = '{default: '0};
   logic rsp_valid, rsp_ready = 1'b0, rsp_hit;
   logic csr_valid = 1'b0, csr_ready;
   rcit_pkg::radius_type csr_radius = '0;
   int error_count, pending_hits;
   bit hold_rsp = 1'b0;
   bit hold_done = 1'b0;
   int hold_cnt = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rect_circle_intersect_test_top #(.COORD_WIDTH(CW), .FRAC_BITS(8)) i_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_corner0_x(crd[0]), .req_corner0_y(crd[1]),
      .req_corner1_x(crd[2]), .req_corner1_y(crd[3]),
      .req_corner2_x(crd[4]), .req_corner2_y(crd[5]),
      .req_corner3_x(crd[6]), .req_corner3_y(crd[7]),
      .req_centre_x(crd[8]), .req_centre_y(crd[9]),
      .rsp_valid, .rsp_ready, .rsp_hit, .csr_valid, .csr_ready, .csr_radius);

   rect_circle_checker #(.COORD_WIDTH(CW)) i_checker (
      .clock, .reset, .req_valid, .req_ready,
      .req_corner0_x(crd[0]), .req_corner0_y(crd[1]),
      .req_corner1_x(crd[2]), .req_corner1_y(crd[3]),
      .req_corner2_x(crd[4]), .req_corner2_y(crd[5]),
      .req_corner3_x(crd[6]), .req_corner3_y(crd[7]),
      .req_centre_x(crd[8]), .req_centre_y(crd[9]),
      .rsp_valid, .rsp_ready, .rsp_hit, .csr_valid, .csr_ready, .csr_radius,
      .error_count, .pending_hits);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 1) ? CMAX : CMIN;
      if (r < 4) return int'($urandom) >>> 11;
      return $urandom_range(0, 8000) - 4000;
   endfunction

   // drive one item and wait for its transfer
   task automatic send_item(int v[10]);
      foreach (crd[i]) crd[i] <= CW'(v[i]);
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_with_gap(int v[10]);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_item(v);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_hits != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_radius(rcit_pkg::radius_type r);
      csr_radius <= r;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_rect(output int v[10]);
      int cx, cy, ax, ay, k, span;
      span = $urandom_range(0, 9) == 0 ? 60000 : 3000;
      cx = $urandom_range(0, 2 * span) - span;
      cy = $urandom_range(0, 2 * span) - span;
      ax = $urandom_range(0, span) - span / 2;
      ay = $urandom_range(0, span) - span / 2;
      k = $urandom_range(0, 1000);
      v[0] = cx; v[1] = cy;
      v[2] = cx + ax; v[3] = cy + ay;
      v[4] = cx + ax - ay * k / 1000; v[5] = cy + ay + ax * k / 1000;
      v[6] = cx - ay * k / 1000; v[7] = cy + ax * k / 1000;
      if ($urandom_range(0, 1)) begin
         v[8] = cx + $urandom_range(0, 2 * span) - span;
         v[9] = cy + $urandom_range(0, 2 * span) - span;
      end else begin
         v[8] = v[2 * $urandom_range(0, 3)] + $urandom_range(0, 600) - 300;
         v[9] = v[2 * $urandom_range(0, 3) + 1] + $urandom_range(0, 600) - 300;
      end
   endtask

   // hold off the receiver once for a long stretch
   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt - 1;
      end else if (hold_rsp && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 60;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   initial begin
      int v[10];
      rcit_pkg::radius_type radii[6];
      radii = '{16'd0, 16'd1, 16'd300, 16'd2000, 16'hFFFF, 16'd128};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: degenerate, extremes, inside, corners, edges
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; send_item(v);
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 100, 0}; send_item(v);
      v = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 0, 0}; send_item(v);
      v = '{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX}; send_item(v);
      v = '{CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, -1, -1}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, 500, 200}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, -100, 0}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, -127, -1}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, 500, -127}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, 500, -128}; send_item(v);
      v = '{0, 0, 1024, 0, 1024, 512, 0, 512, 1152, 600}; send_item(v);
      v = '{0, 0, 0, 0, 1024, 512, 0, 512, 1100, 600}; send_item(v);
      v = '{100, 0, 0, 100, -100, 0, 0, -100, 0, 0}; send_item(v);
      v = '{100, 0, 0, 100, -100, 0, 0, -100, 90, 90}; send_item(v);
      drain();

      foreach (radii[p]) begin
         write_radius(radii[p]);
         for (int n = 0; n < 215; n++) begin
            if ($urandom_range(0, 9) < 8) random_rect(v);
            else foreach (v[i]) v[i] = rand_coord();
            if (n == 100 && p == 2) begin
               hold_rsp <= 1'b1;
               send_item(v);
               repeat (40) begin
                  random_rect(v);
                  send_item(v);
               end
               hold_rsp <= 1'b0;
            end
            if (n == 60) drain();
            send_with_gap(v);
         end
         drain();
      end

      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
